[design/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths, codes and the 32-bit saturation helper for the
// complex-number ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OPW   = 32;   // operand / result part width
  localparam int PRODW = 64;   // 32x32 product
  localparam int SUMW  = 66;   // sum of two products, signed, with headroom
  localparam int REMW  = 96;   // divider remainder / shifted divisor
  localparam int QW    = 32;   // quotient / root bits, one per stage
  localparam int TOLW  = 31;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_ABSSQ = 3'd4,
    MODE_MAG   = 3'd5,
    MODE_CONJ  = 3'd6,
    MODE_EQ    = 3'd7
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic signed [SUMW-1:0] SAT_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [SUMW-1:0] SAT_MIN = -66'sh0_8000_0000;

  typedef struct packed {
    logic                  ovf;
    logic signed [OPW-1:0] val;
  } sat_t;

  // clamp a wide signed value into 32 signed bits
  function automatic sat_t sat_s(input logic signed [SUMW-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = SAT_MAX[OPW-1:0];
    end else if (v < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = SAT_MIN[OPW-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[OPW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/complex_arithmetic_unit.sv]
// Stages: 3 front stages, one prep stage, 32 quotient/root stages, one output
//   register.
// Throughput: one request per cycle unless the output stalls; the quotient and square-root bit
//   stages are unrolled, one bit each, so every stage is free each cycle.
// The whole pipe advances together while the output register is empty or taken.
// Reset: synchronous active-low, clears valid bits and the tolerance register.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point parts: add, sub, mul, div,
// squared magnitude, magnitude, conjugate and tolerance equality.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_mode,
  input  wire logic signed [OPW-1:0] in_a_real,
  input  wire logic signed [OPW-1:0] in_a_imag,
  input  wire logic signed [OPW-1:0] in_b_real,
  input  wire logic signed [OPW-1:0] in_b_imag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OPW-1:0]      out_result_real,
  output logic signed [OPW-1:0]      out_result_imag,
  output logic                       out_are_equal,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [TOLW-1:0]       cfg_data
);

  typedef struct packed {
    mode_t                 mode;
    logic signed [OPW-1:0] rr;
    logic signed [OPW-1:0] ri;
    logic                  eq;
    logic                  ovf;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic [PRODW-1:0]      den;
    logic [REMW-1:0]       rem_re;
    logic [REMW-1:0]       rem_im;
    logic [QW-1:0]         q_re;
    logic [QW-1:0]         q_im;
    logic [PRODW-1:0]      sq_v;
    logic [PRODW-1:0]      sq_res;
  } lane_t;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // tolerance register
  logic [TOLW-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // ---------------- stage 0: input register ----------------
  logic                  s0_v_r;
  mode_t                 s0_mode_r;
  logic signed [OPW-1:0] s0_ar_r, s0_ai_r, s0_br_r, s0_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= mode_t'(in_mode);
      s0_ar_r   <= in_a_real;
      s0_ai_r   <= in_a_imag;
      s0_br_r   <= in_b_real;
      s0_bi_r   <= in_b_imag;
    end
  end

  // ---------------- stage 1: products and simple ops ----------------
  logic                    s1_v_r;
  mode_t                   s1_mode_r;
  logic signed [PRODW-1:0] s1_pa_r, s1_pb_r, s1_pc_r, s1_pd_r;
  logic [PRODW-1:0]        s1_qr_r, s1_qi_r;
  logic signed [OPW-1:0]   s1_rr_r, s1_ri_r;
  logic                    s1_eq_r, s1_ovf_r, s1_dz_r;

  logic signed [OPW-1:0]   y0, y1;
  logic signed [PRODW-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt, qr_nxt, qi_nxt;
  logic signed [OPW:0]     d_re, d_im, ad_re, ad_im;
  sat_t                    sa_re, sa_im;
  logic signed [OPW-1:0]   rr_nxt, ri_nxt;
  logic                    eq_nxt, ovf_nxt;

  always_comb begin
    // squared-magnitude modes reuse the first two multipliers
    y0 = (s0_mode_r == MODE_ABSSQ || s0_mode_r == MODE_MAG) ? s0_ar_r : s0_br_r;
    y1 = (s0_mode_r == MODE_ABSSQ || s0_mode_r == MODE_MAG) ? s0_ai_r : s0_bi_r;
    pa_nxt = s0_ar_r * y0;
    pb_nxt = s0_ai_r * y1;
    pc_nxt = s0_ar_r * s0_bi_r;
    pd_nxt = s0_ai_r * s0_br_r;
    qr_nxt = s0_br_r * s0_br_r;
    qi_nxt = s0_bi_r * s0_bi_r;

    d_re  = (OPW+1)'(s0_ar_r) - (OPW+1)'(s0_br_r);
    d_im  = (OPW+1)'(s0_ai_r) - (OPW+1)'(s0_bi_r);
    ad_re = d_re[OPW] ? -d_re : d_re;
    ad_im = d_im[OPW] ? -d_im : d_im;

    sa_re  = '0;
    sa_im  = '0;
    eq_nxt = 1'b0;
    unique case (s0_mode_r)
      MODE_ADD: begin
        sa_re = sat_s(SUMW'(s0_ar_r) + SUMW'(s0_br_r));
        sa_im = sat_s(SUMW'(s0_ai_r) + SUMW'(s0_bi_r));
      end
      MODE_SUB: begin
        sa_re = sat_s(SUMW'(s0_ar_r) - SUMW'(s0_br_r));
        sa_im = sat_s(SUMW'(s0_ai_r) - SUMW'(s0_bi_r));
      end
      MODE_CONJ: begin
        sa_re = sat_s(SUMW'(s0_ar_r));
        sa_im = sat_s(-SUMW'(s0_ai_r));
      end
      MODE_EQ: begin
        eq_nxt = ($unsigned(ad_re) <= {2'b00, tol_r}) &&
                 ($unsigned(ad_im) <= {2'b00, tol_r});
      end
      default: begin
        sa_re = '0;
        sa_im = '0;
      end
    endcase
    rr_nxt  = sa_re.val;
    ri_nxt  = sa_im.val;
    ovf_nxt = sa_re.ovf | sa_im.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= s0_mode_r;
      s1_pa_r   <= pa_nxt;
      s1_pb_r   <= pb_nxt;
      s1_pc_r   <= pc_nxt;
      s1_pd_r   <= pd_nxt;
      s1_qr_r   <= $unsigned(qr_nxt);
      s1_qi_r   <= $unsigned(qi_nxt);
      s1_rr_r   <= rr_nxt;
      s1_ri_r   <= ri_nxt;
      s1_eq_r   <= eq_nxt;
      s1_ovf_r  <= ovf_nxt;
      s1_dz_r   <= (s0_br_r == '0) && (s0_bi_r == '0);
    end
  end

  // ---------------- stage 2: sums ----------------
  logic                   s2_v_r;
  mode_t                  s2_mode_r;
  logic signed [SUMW-1:0] s2_re_r, s2_im_r;
  logic [PRODW-1:0]       s2_den_r;
  logic signed [OPW-1:0]  s2_rr_r, s2_ri_r;
  logic                   s2_eq_r, s2_ovf_r, s2_dz_r;
  logic signed [SUMW-1:0] re_nxt, im_nxt;

  always_comb begin
    if (s1_mode_r == MODE_MUL) begin
      re_nxt = SUMW'(s1_pa_r) - SUMW'(s1_pb_r);
    end else begin
      re_nxt = SUMW'(s1_pa_r) + SUMW'(s1_pb_r);
    end
    if (s1_mode_r == MODE_DIV) begin
      im_nxt = SUMW'(s1_pd_r) - SUMW'(s1_pc_r);
    end else begin
      im_nxt = SUMW'(s1_pc_r) + SUMW'(s1_pd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode_r <= s1_mode_r;
      s2_re_r   <= re_nxt;
      s2_im_r   <= im_nxt;
      s2_den_r  <= s1_qr_r + s1_qi_r;
      s2_rr_r   <= s1_rr_r;
      s2_ri_r   <= s1_ri_r;
      s2_eq_r   <= s1_eq_r;
      s2_ovf_r  <= s1_ovf_r;
      s2_dz_r   <= s1_dz_r;
    end
  end

  // ---------------- stage 3: truncation and divide / root setup ----------------
  lane_t            lane_r [QW+1];
  lane_t            lane_nxt [QW+1];
  logic             lane_v_r [QW+1];
  logic [PRODW-1:0] mag_re, mag_im;
  logic [REMW-1:0]  den_lim;
  sat_t             sm_re, sm_im;

  always_comb begin
    mag_re  = s2_re_r[SUMW-1] ? PRODW'(-s2_re_r) : PRODW'(s2_re_r);
    mag_im  = s2_im_r[SUMW-1] ? PRODW'(-s2_im_r) : PRODW'(s2_im_r);
    // quotient reaches 2^32 exactly when |num| >= den << (32 - frac)
    den_lim = REMW'(s2_den_r) << (QW - FRAC_BITS);
    sm_re   = sat_s(s2_re_r >>> FRAC_BITS);
    sm_im   = sat_s(s2_im_r >>> FRAC_BITS);

    lane_nxt[0].mode   = s2_mode_r;
    lane_nxt[0].rr     = s2_rr_r;
    lane_nxt[0].ri     = s2_ri_r;
    lane_nxt[0].eq     = s2_eq_r;
    lane_nxt[0].ovf    = s2_ovf_r;
    lane_nxt[0].dz     = s2_dz_r;
    lane_nxt[0].neg_re = s2_re_r[SUMW-1];
    lane_nxt[0].neg_im = s2_im_r[SUMW-1];
    lane_nxt[0].big_re = REMW'(mag_re) >= den_lim;
    lane_nxt[0].big_im = REMW'(mag_im) >= den_lim;
    lane_nxt[0].den    = s2_den_r;
    lane_nxt[0].rem_re = REMW'(mag_re) << FRAC_BITS;
    lane_nxt[0].rem_im = REMW'(mag_im) << FRAC_BITS;
    lane_nxt[0].q_re   = '0;
    lane_nxt[0].q_im   = '0;
    lane_nxt[0].sq_v   = s2_re_r[PRODW-1:0];
    lane_nxt[0].sq_res = '0;

    if (s2_mode_r == MODE_MUL) begin
      lane_nxt[0].rr  = sm_re.val;
      lane_nxt[0].ri  = sm_im.val;
      lane_nxt[0].ovf = sm_re.ovf | sm_im.ovf;
    end else if (s2_mode_r == MODE_ABSSQ) begin
      lane_nxt[0].rr  = sm_re.val;
      lane_nxt[0].ri  = '0;
      lane_nxt[0].ovf = sm_re.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_v_r[0] <= 1'b0;
    end else if (en) begin
      lane_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r[0] <= lane_nxt[0];
    end
  end

  // ---------------- quotient / root stages, one bit each ----------------
  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int BIT = QW - 1 - k;
    localparam logic [PRODW-1:0] ONE = PRODW'(1) << (2*QW - 2 - 2*k);
    logic [REMW-1:0]  dsh;
    logic [PRODW-1:0] trial;

    always_comb begin
      dsh   = REMW'(lane_r[k].den) << BIT;
      trial = lane_r[k].sq_res + ONE;
      lane_nxt[k+1] = lane_r[k];
      if (lane_r[k].rem_re >= dsh) begin
        lane_nxt[k+1].rem_re = lane_r[k].rem_re - dsh;
        lane_nxt[k+1].q_re   = {lane_r[k].q_re[QW-2:0], 1'b1};
      end else begin
        lane_nxt[k+1].q_re   = {lane_r[k].q_re[QW-2:0], 1'b0};
      end
      if (lane_r[k].rem_im >= dsh) begin
        lane_nxt[k+1].rem_im = lane_r[k].rem_im - dsh;
        lane_nxt[k+1].q_im   = {lane_r[k].q_im[QW-2:0], 1'b1};
      end else begin
        lane_nxt[k+1].q_im   = {lane_r[k].q_im[QW-2:0], 1'b0};
      end
      if (lane_r[k].sq_v >= trial) begin
        lane_nxt[k+1].sq_v   = lane_r[k].sq_v - trial;
        lane_nxt[k+1].sq_res = (lane_r[k].sq_res >> 1) + ONE;
      end else begin
        lane_nxt[k+1].sq_res = lane_r[k].sq_res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lane_v_r[k+1] <= 1'b0;
      end else if (en) begin
        lane_v_r[k+1] <= lane_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[k+1] <= lane_nxt[k+1];
      end
    end
  end

  // ---------------- output stage ----------------
  lane_t                  fin;
  logic [QW+1:0]          dm_re, dm_im;
  logic signed [SUMW-1:0] dv_re, dv_im;
  sat_t                   sd_re, sd_im, sq;
  logic signed [OPW-1:0]  res_re_nxt, res_im_nxt;
  logic [1:0]             st_nxt;

  logic                  out_valid_r;
  logic signed [OPW-1:0] out_re_r, out_im_r;
  logic                  out_eq_r;
  logic [1:0]            out_st_r;

  always_comb begin
    fin   = lane_r[QW];
    dm_re = fin.big_re ? (QW+2)'(1) << QW : (QW+2)'(fin.q_re);
    dm_im = fin.big_im ? (QW+2)'(1) << QW : (QW+2)'(fin.q_im);
    dv_re = $signed(SUMW'(dm_re));
    dv_im = $signed(SUMW'(dm_im));
    if (fin.neg_re) begin
      dv_re = -dv_re;
    end
    if (fin.neg_im) begin
      dv_im = -dv_im;
    end
    sd_re = sat_s(dv_re);
    sd_im = sat_s(dv_im);
    sq    = sat_s($signed(SUMW'(fin.sq_res[QW-1:0])));

    res_re_nxt = fin.rr;
    res_im_nxt = fin.ri;
    st_nxt     = fin.ovf ? ST_OVF : ST_OK;
    priority if (fin.mode == MODE_DIV && fin.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      st_nxt     = ST_DIV0;
    end else if (fin.mode == MODE_DIV) begin
      res_re_nxt = sd_re.val;
      res_im_nxt = sd_im.val;
      st_nxt     = (sd_re.ovf | sd_im.ovf) ? ST_OVF : ST_OK;
    end else if (fin.mode == MODE_MAG) begin
      res_re_nxt = sq.val;
      res_im_nxt = '0;
      st_nxt     = sq.ovf ? ST_OVF : ST_OK;
    end else begin
      res_re_nxt = fin.rr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lane_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= res_re_nxt;
      out_im_r <= res_im_nxt;
      out_eq_r <= fin.eq;
      out_st_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_real = out_re_r;
  assign out_result_imag = out_im_r;
  assign out_are_equal   = out_eq_r;
  assign out_status      = out_st_r;

  // ---------------- assertions ----------------
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIV0) |->
      (out_result_real == '0 && out_result_imag == '0 && !out_are_equal))
    else $error("zero-divisor result not cleared");

  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_are_equal) |->
      (out_status == ST_OK && out_result_real == '0 && out_result_imag == '0))
    else $error("equality verdict with nonzero result");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s0_v_r)
    else $error("accepted request lost at entry");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s2_v_r) && $stable(lane_v_r[QW]) && $stable(out_re_r)))
    else $error("pipeline moved during stall");

  a_mag_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_v_r[QW] && en && fin.mode == MODE_MAG) |=> (out_result_imag == '0))
    else $error("magnitude result has imaginary part");

endmodule

`default_nettype wire

[bench/complex_arithmetic_unit_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_check
// Watches the request, result and tolerance channels of the complex ALU,
// predicts each result from the accepted request and the current tolerance,
// and compares results in order, field by field.
// ----------------------------------------------------------------------------

module complex_arithmetic_unit_check
  import cau_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_mode,
  input  logic signed [OPW-1:0] in_a_real,
  input  logic signed [OPW-1:0] in_a_imag,
  input  logic signed [OPW-1:0] in_b_real,
  input  logic signed [OPW-1:0] in_b_imag,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [OPW-1:0] out_result_real,
  input  logic signed [OPW-1:0] out_result_imag,
  input  logic                  out_are_equal,
  input  logic [1:0]            out_status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [TOLW-1:0]       cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [OPW-1:0] re;
    logic signed [OPW-1:0] im;
    logic                  eq;
    logic [1:0]            st;
  } cplx_result_t;

  cplx_result_t  result_q[$];
  logic [TOLW-1:0] tolerance;

  // {overflow, 32-bit clamped value}
  function automatic logic [OPW:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -128'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[OPW-1:0]};
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // truncated (num << FB) / den, den nonzero
  function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                               input logic [127:0] den);
    logic [127:0] mag;
    mag = num < 0 ? -num : num;
    mag = (mag << FB) / den;
    return num < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cplx_result_t predict(input logic [2:0] m,
                                           input logic signed [OPW-1:0] ar, ai, br, bi);
    cplx_result_t r;
    logic signed [127:0] xr, xi, yr, yi, wr, wi, dr, di;
    logic [127:0] den;
    logic [OPW:0] cr, ci;
    xr = ar; xi = ai; yr = br; yi = bi;
    cr = 0; ci = 0;
    r.eq = 1'b0;
    r.st = ST_OK;
    case (mode_t'(m))
      MODE_ADD: begin
        cr = clamp32(xr + yr);
        ci = clamp32(xi + yi);
      end
      MODE_SUB: begin
        cr = clamp32(xr - yr);
        ci = clamp32(xi - yi);
      end
      MODE_MUL: begin
        wr = xr * yr - xi * yi;
        wi = xr * yi + xi * yr;
        cr = clamp32(wr >>> FB);
        ci = clamp32(wi >>> FB);
      end
      MODE_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.st = ST_DIV0;
        end else begin
          cr = clamp32(quot(xr * yr + xi * yi, den));
          ci = clamp32(quot(xi * yr - xr * yi, den));
        end
      end
      MODE_ABSSQ: cr = clamp32((xr * xr + xi * xi) >>> FB);
      MODE_MAG:   cr = clamp32($signed({64'd0, floor_sqrt(64'(xr * xr + xi * xi))}));
      MODE_CONJ: begin
        cr = clamp32(xr);
        ci = clamp32(-xi);
      end
      default: begin
        dr = xr - yr;
        di = xi - yi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.eq = (dr <= tolerance) && (di <= tolerance);
      end
    endcase
    r.re = cr[OPW-1:0];
    r.im = ci[OPW-1:0];
    if ((cr[OPW] || ci[OPW]) && r.st == ST_OK) r.st = ST_OVF;
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    cplx_result_t e;
    if (!rst_n) begin
      tolerance <= '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (in_valid && in_ready)
        result_q.push_back(predict(in_mode, in_a_real, in_a_imag, in_b_real, in_b_imag));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e.re !== out_result_real || e.im !== out_result_imag ||
              e.eq !== out_are_equal || e.st !== out_status) begin
            fail_count <= fail_count + 1;
            if (e.re !== out_result_real)
              $error("result_real expected %0d got %0d", e.re, out_result_real);
            if (e.im !== out_result_imag)
              $error("result_imag expected %0d got %0d", e.im, out_result_imag);
            if (e.eq !== out_are_equal)
              $error("are_equal expected %0d got %0d", e.eq, out_are_equal);
            if (e.st !== out_status)
              $error("status expected %0d got %0d", e.st, out_status);
          end
        end
      end
    end
  end

endmodule

[bench/complex_arithmetic_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test
// Drives directed corner requests and random requests into the complex ALU
// under several tolerance settings and idle patterns; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------

module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int  LATENCY   = 40;
  localparam int  MAX_CYCLE = 300000;
  localparam logic signed [OPW-1:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [OPW-1:0] PMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_mode = '0;
  logic signed [OPW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OPW-1:0] out_result_real, out_result_imag;
  logic out_are_equal;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOLW-1:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 9;
  int recv_stall_pct = 45;
  int cycle = 0;

  complex_arithmetic_unit u_dut (.*);
  complex_arithmetic_unit_check u_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    out_ready <= $urandom_range(99) >= recv_stall_pct;
    if (cycle > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(input mode_t m, input logic signed [OPW-1:0] ar, ai, br, bi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOLW-1:0] tol);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [OPW-1:0] rand_part();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $signed(32'($urandom_range(2 * 1048576))) - 32'sd1048576;
      2: return $signed(32'($urandom_range(2 * 16777216))) - 32'sd16777216;
      3: case ($urandom_range(4))
           0: return PMAX;
           1: return PMIN;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      default: return $signed(32'($urandom_range(131072))) - 32'sd65536;
    endcase
  endfunction

  task automatic random_batch(input int n);
    mode_t m;
    logic signed [OPW-1:0] ar, ai, br, bi;
    repeat (n) begin
      m = mode_t'($urandom_range(7));
      ar = rand_part();
      ai = rand_part();
      br = rand_part();
      bi = rand_part();
      // near-equal operands exercise the tolerance compare
      if (m == MODE_EQ && $urandom_range(1)) begin
        br = ar + $signed(32'($urandom_range(4000))) - 32'sd2000;
        bi = ai + $signed(32'($urandom_range(4000))) - 32'sd2000;
      end
      if (m == MODE_DIV && $urandom_range(9) == 0) begin
        br = 0;
        bi = 0;
      end
      send(m, ar, ai, br, bi);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at reset tolerance of zero
    send(MODE_ADD, PMAX, PMIN, PMAX, PMIN);
    send(MODE_ADD, 0, 0, 0, 0);
    send(MODE_SUB, PMIN, PMAX, PMAX, PMIN);
    send(MODE_SUB, 32'sh0001_0000, 5, 32'sh0002_0000, -7);
    send(MODE_MUL, PMAX, PMAX, PMAX, PMAX);
    send(MODE_MUL, PMIN, PMIN, PMIN, PMIN);
    send(MODE_MUL, -1, 0, 1, 0);
    send(MODE_MUL, 32'sh0003_0000, 32'sh0004_0000, 32'sh0001_8000, -32'sh0002_0000);
    send(MODE_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
    send(MODE_DIV, 32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000);
    send(MODE_DIV, PMAX, PMIN, 1, 0);
    send(MODE_DIV, -7, 3, PMIN, PMAX);
    send(MODE_ABSSQ, PMIN, PMIN, 0, 0);
    send(MODE_ABSSQ, 32'sh0003_0000, -32'sh0004_0000, PMAX, PMIN);
    send(MODE_MAG, PMIN, PMIN, 0, 0);
    send(MODE_MAG, 3, 4, 0, 0);
    send(MODE_MAG, 0, 0, 0, 0);
    send(MODE_CONJ, PMAX, PMIN, 0, 0);
    send(MODE_CONJ, PMIN, 32'sh0001_0000, 0, 0);
    send(MODE_EQ, 100, -100, 100, -100);
    send(MODE_EQ, 100, -100, 101, -100);
    send(MODE_EQ, PMAX, PMIN, PMIN, PMAX);

    random_batch(60);
    set_tolerance(TOLW'('1));
    send(MODE_EQ, PMAX, PMIN, PMIN, PMAX);
    send(MODE_EQ, PMAX, 0, 0, 0);
    random_batch(70);
    set_tolerance(TOLW'(1000));
    random_batch(70);

    send_idle_pct = 45;
    recv_stall_pct = 9;
    set_tolerance(TOLW'($urandom()));
    random_batch(60);
    drain();   // hold off until every request has returned
    set_tolerance(TOLW'(0));
    random_batch(60);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_tolerance(TOLW'($urandom_range(2000)));
    random_batch(80);

    drain();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
